>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file sdm_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

>>> design/sdm_pkg.sv
// ----------------------------------------------------------------------------
// sdm_pkg
// Shared types, weights and channel tables of the surround downmix matrix.
// ----------------------------------------------------------------------------
package sdm_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int NUM_CH           = 12;
  localparam int NUM_LANES        = 2;
  localparam int NUM_TERMS        = 7;
  localparam int COEF_W           = 16;
  localparam int FRAC_BITS        = 15;
  localparam int OUT_CH_W         = 4;
  localparam int NUM_SIX          = 6;

  typedef logic [OUT_CH_W-1:0] out_ch_t;
  typedef logic [COEF_W-1:0]   coef_t;
  typedef logic [3:0]          ch_idx_t;

  localparam out_ch_t OUT_CH_RESET   = 4'd2;
  localparam out_ch_t CNT_SILENT     = 4'd0;
  localparam out_ch_t CNT_MONO       = 4'd1;
  localparam out_ch_t CNT_SIX        = 4'd6;
  localparam out_ch_t CNT_PASS_MIN   = 4'd12;
  localparam out_ch_t CNT_PASS_MAX   = 4'd15;

  // Q1.15 weights
  localparam coef_t CO_ONE  = 16'd32768;
  localparam coef_t CO_0707 = 16'd23167;
  localparam coef_t CO_HALF = 16'd16384;
  localparam coef_t CO_035  = 16'd11469;
  localparam coef_t CO_02   = 16'd6554;
  localparam coef_t CO_ZERO = 16'd0;

  typedef enum logic [2:0] {
    MODE_SILENT,
    MODE_MONO,
    MODE_STEREO,
    MODE_SIX,
    MODE_PASS
  } mode_t;

  typedef struct packed {
    logic  vld;
    mode_t mode;
  } ctl_t;

  // stereo fold-down: lane 0 left, lane 1 right
  localparam ch_idx_t STEREO_SRC [NUM_LANES][NUM_TERMS] = '{
    '{4'd0, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd10},
    '{4'd1, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11}
  };
  localparam coef_t STEREO_COEF [NUM_TERMS] = '{
    CO_ONE, CO_0707, CO_02, CO_HALF, CO_HALF, CO_035, CO_035
  };

  // mono fold-down: C + 0.5L + 0.5R
  localparam ch_idx_t MONO_SRC [NUM_TERMS] = '{
    4'd2, 4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0
  };
  localparam coef_t MONO_COEF [NUM_TERMS] = '{
    CO_ONE, CO_HALF, CO_HALF, CO_ZERO, CO_ZERO, CO_ZERO, CO_ZERO
  };

  function automatic mode_t decode_mode(input out_ch_t cnt);
    mode_t m;
    unique case (cnt) inside
      CNT_SILENT:                   m = MODE_SILENT;
      CNT_MONO:                     m = MODE_MONO;
      CNT_SIX:                      m = MODE_SIX;
      [CNT_PASS_MIN:CNT_PASS_MAX]:  m = MODE_PASS;
      default:                      m = MODE_STEREO;
    endcase
    return m;
  endfunction

endpackage

>>> design/sdm_term_gen.sv
// ----------------------------------------------------------------------------
// sdm_term_gen
// Weighted product stage: seven constant-weight products per mix lane.
// ----------------------------------------------------------------------------
module sdm_term_gen #(
  parameter int SAMPLE_WIDTH = sdm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  sdm_pkg::ctl_t                                       ctl_in,
  input  logic [sdm_pkg::NUM_CH-1:0][SAMPLE_WIDTH-1:0]        smp_in,
  output sdm_pkg::ctl_t                                       ctl_out,
  output logic [sdm_pkg::NUM_LANES-1:0][sdm_pkg::NUM_TERMS-1:0]
               [SAMPLE_WIDTH+sdm_pkg::COEF_W:0]               term_out
);
  import sdm_pkg::*;

  localparam int PW = SAMPLE_WIDTH + COEF_W + 1;

  ctl_t                                       ctl_r;
  logic [NUM_LANES-1:0][NUM_TERMS-1:0][PW-1:0] term_r;
  logic [NUM_LANES-1:0][NUM_TERMS-1:0][PW-1:0] term_nxt;

  always_comb begin
    ch_idx_t           src;
    coef_t             coef;
    logic signed [PW-1:0] a;
    logic signed [PW-1:0] b;
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        if (ctl_in.mode == MODE_MONO) begin
          src  = MONO_SRC[k];
          coef = MONO_COEF[k];
        end else begin
          src  = STEREO_SRC[l][k];
          coef = STEREO_COEF[k];
        end
        a = {{(PW-COEF_W){1'b0}}, coef};
        b = {{(PW-SAMPLE_WIDTH){smp_in[src][SAMPLE_WIDTH-1]}}, smp_in[src]};
        term_nxt[l][k] = a * b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

  assign ctl_out  = ctl_r;
  assign term_out = term_r;

endmodule

>>> design/sdm_mix_sum.sv
// ----------------------------------------------------------------------------
// sdm_mix_sum
// Two-stage adder tree per lane, then round to nearest and saturate.
// ----------------------------------------------------------------------------
module sdm_mix_sum #(
  parameter int SAMPLE_WIDTH = sdm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  sdm_pkg::ctl_t                                       ctl_in,
  input  logic [sdm_pkg::NUM_LANES-1:0][sdm_pkg::NUM_TERMS-1:0]
               [SAMPLE_WIDTH+sdm_pkg::COEF_W:0]               term_in,
  output sdm_pkg::ctl_t                                       ctl_out,
  output logic [sdm_pkg::NUM_LANES-1:0][SAMPLE_WIDTH-1:0]     mix_out
);
  import sdm_pkg::*;

  localparam int PW    = SAMPLE_WIDTH + COEF_W + 1;
  localparam int AW    = PW + 1;
  localparam int QW    = AW - FRAC_BITS;
  localparam int SPLIT = 4;

  localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [QW-1:0] Q_MAX =
    {{(QW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN =
    {{(QW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  ctl_t                                  ctl3_r;
  ctl_t                                  ctl4_r;
  logic [NUM_LANES-1:0][AW-1:0]          part_a_r;
  logic [NUM_LANES-1:0][AW-1:0]          part_b_r;
  logic [NUM_LANES-1:0][AW-1:0]          part_a_nxt;
  logic [NUM_LANES-1:0][AW-1:0]          part_b_nxt;
  logic [NUM_LANES-1:0][SAMPLE_WIDTH-1:0] mix_r;
  logic [NUM_LANES-1:0][SAMPLE_WIDTH-1:0] mix_nxt;

  always_comb begin
    logic signed [AW-1:0] ext;
    for (int l = 0; l < NUM_LANES; l++) begin
      part_a_nxt[l] = '0;
      part_b_nxt[l] = '0;
      for (int k = 0; k < NUM_TERMS; k++) begin
        ext = {term_in[l][k][PW-1], term_in[l][k]};
        if (k < SPLIT) begin
          part_a_nxt[l] = part_a_nxt[l] + ext;
        end else begin
          part_b_nxt[l] = part_b_nxt[l] + ext;
        end
      end
    end
  end

  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [QW-1:0] q;
    for (int l = 0; l < NUM_LANES; l++) begin
      acc = $signed(part_a_r[l]) + $signed(part_b_r[l]) + ROUND_HALF;
      q   = acc[AW-1:FRAC_BITS];
      if (q > Q_MAX) begin
        mix_nxt[l] = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end else if (q < Q_MIN) begin
        mix_nxt[l] = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
        mix_nxt[l] = q[SAMPLE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl3_r <= ctl_in;
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    part_a_r <= part_a_nxt;
    part_b_r <= part_b_nxt;
    mix_r    <= mix_nxt;
  end

  assign ctl_out = ctl4_r;
  assign mix_out = mix_r;

endmodule

>>> design/surround_downmix_matrix_unit.sv
// Pipeline: a frame accepted at one edge passes the input, product, two adder and
//   output registers in turn before it shows on the out_ ports, with out_valid.
// Throughput: one frame per cycle; busy stays low, the five-stage pipe never stalls.
// Reset (rst_n low, synchronous): all stage valid bits clear and out_channels
//   returns to 2.
// ----------------------------------------------------------------------------
// surround_downmix_matrix_unit
// 7.1.4 frame to twelve output slots: passthrough, 5.1 copy, stereo or mono
// fold-down with Q1.15 weights, or silence, by the configured channel count.
// ----------------------------------------------------------------------------
module surround_downmix_matrix_unit #(
  parameter int SAMPLE_WIDTH = sdm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [sdm_pkg::OUT_CH_W-1:0]   cfg_wr_data,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] in_front_left,
  input  logic signed [SAMPLE_WIDTH-1:0] in_front_right,
  input  logic signed [SAMPLE_WIDTH-1:0] in_center,
  input  logic signed [SAMPLE_WIDTH-1:0] in_low_freq,
  input  logic signed [SAMPLE_WIDTH-1:0] in_side_left,
  input  logic signed [SAMPLE_WIDTH-1:0] in_side_right,
  input  logic signed [SAMPLE_WIDTH-1:0] in_rear_left,
  input  logic signed [SAMPLE_WIDTH-1:0] in_rear_right,
  input  logic signed [SAMPLE_WIDTH-1:0] in_top_front_left,
  input  logic signed [SAMPLE_WIDTH-1:0] in_top_front_right,
  input  logic signed [SAMPLE_WIDTH-1:0] in_top_rear_left,
  input  logic signed [SAMPLE_WIDTH-1:0] in_top_rear_right,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_0,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_1,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_2,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_3,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_4,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_5,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_6,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_7,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_8,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_9,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_10,
  output logic signed [SAMPLE_WIDTH-1:0] out_chan_11
);
  import sdm_pkg::*;

  localparam int PW = SAMPLE_WIDTH + COEF_W + 1;

  typedef logic [NUM_CH-1:0][SAMPLE_WIDTH-1:0] frame_t;

  out_ch_t cfg_out_channels_r;
  ctl_t    ctl1_r;
  ctl_t    ctl1_nxt;
  ctl_t    ctl2;
  ctl_t    ctl4;
  frame_t  smp1_r;
  frame_t  smp1_nxt;
  frame_t  smp2_r;
  frame_t  smp3_r;
  frame_t  smp4_r;
  frame_t  out_chan_r;
  frame_t  out_chan_nxt;
  logic    out_valid_r;

  logic [NUM_LANES-1:0][NUM_TERMS-1:0][PW-1:0] term2;
  logic [NUM_LANES-1:0][SAMPLE_WIDTH-1:0]      mix4;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_out_channels_r <= OUT_CH_RESET;
    end else if (cfg_wr_en) begin
      cfg_out_channels_r <= cfg_wr_data;
    end
  end

  always_comb begin
    ctl1_nxt.vld  = start & ~busy;
    ctl1_nxt.mode = decode_mode(cfg_out_channels_r);
    smp1_nxt = {in_top_rear_right, in_top_rear_left, in_top_front_right,
                in_top_front_left, in_rear_right, in_rear_left, in_side_right,
                in_side_left, in_low_freq, in_center, in_front_right,
                in_front_left};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl1_r      <= ctl1_nxt;
      out_valid_r <= ctl4.vld;
    end
  end

  // samples ride alongside the mix pipe for the copy modes
  always_ff @(posedge clk) begin
    smp1_r     <= smp1_nxt;
    smp2_r     <= smp1_r;
    smp3_r     <= smp2_r;
    smp4_r     <= smp3_r;
    out_chan_r <= out_chan_nxt;
  end

  sdm_term_gen #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_term_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (ctl1_r),
    .smp_in   (smp1_r),
    .ctl_out  (ctl2),
    .term_out (term2)
  );

  sdm_mix_sum #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mix_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl2),
    .term_in (term2),
    .ctl_out (ctl4),
    .mix_out (mix4)
  );

  always_comb begin
    out_chan_nxt = '0;
    case (ctl4.mode)
      MODE_PASS: begin
        out_chan_nxt = smp4_r;
      end
      MODE_SIX: begin
        for (int k = 0; k < NUM_SIX; k++) begin
          out_chan_nxt[k] = smp4_r[k];
        end
      end
      MODE_STEREO: begin
        out_chan_nxt[0] = mix4[0];
        out_chan_nxt[1] = mix4[1];
      end
      MODE_MONO: begin
        out_chan_nxt[0] = mix4[0];
      end
      default: begin
        out_chan_nxt = '0;
      end
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_chan_0  = out_chan_r[0];
  assign out_chan_1  = out_chan_r[1];
  assign out_chan_2  = out_chan_r[2];
  assign out_chan_3  = out_chan_r[3];
  assign out_chan_4  = out_chan_r[4];
  assign out_chan_5  = out_chan_r[5];
  assign out_chan_6  = out_chan_r[6];
  assign out_chan_7  = out_chan_r[7];
  assign out_chan_8  = out_chan_r[8];
  assign out_chan_9  = out_chan_r[9];
  assign out_chan_10 = out_chan_r[10];
  assign out_chan_11 = out_chan_r[11];

endmodule

>>> design/sdm_checker.sv
// ----------------------------------------------------------------------------
// sdm_checker
// Port-level checks of the downmix unit: strobe timing and copy-mode data.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdm_checker #(
  parameter int SAMPLE_WIDTH = sdm_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic signed [SAMPLE_WIDTH-1:0] in_front_left,
  input logic signed [SAMPLE_WIDTH-1:0] in_top_rear_right,
  input logic                           out_valid,
  input logic signed [SAMPLE_WIDTH-1:0] out_chan_0,
  input logic signed [SAMPLE_WIDTH-1:0] out_chan_2,
  input logic signed [SAMPLE_WIDTH-1:0] out_chan_6,
  input logic signed [SAMPLE_WIDTH-1:0] out_chan_11
);

  // every accepted frame comes out as an out_valid strobe
  `ASSERT_CLK(a_frame_out, clk, rst_n, (start && !busy) |-> ##5 out_valid, "frame lost")

  // no strobe without a matching transfer in
  `ASSERT_CLK(a_no_extra, clk, rst_n, !(start && !busy) |-> ##5 !out_valid, "spurious strobe")

  // height slots only carry data in passthrough, which copies every slot
  `ASSERT_CLK(a_pass_copy, clk, rst_n,
    (out_valid && out_chan_6 != '0) |-> (out_chan_11 == $past(in_top_rear_right, 5)),
    "passthrough slot mismatch")

  // slot 2 only carries data in a copy mode, where slot 0 is front left
  `ASSERT_CLK(a_copy_front, clk, rst_n,
    (out_valid && out_chan_2 != '0) |-> (out_chan_0 == $past(in_front_left, 5)),
    "copy slot 0 mismatch")

endmodule

bind surround_downmix_matrix_unit sdm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sdm_checker (.*);
